@@ design/crc_checked_command_frame_parser_core_assert.svh @@
// assertion macros shared by the frame parser modules
`ifndef CRC_CHECKED_COMMAND_FRAME_PARSER_CORE_ASSERT_SVH
`define CRC_CHECKED_COMMAND_FRAME_PARSER_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define CCFP_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ccfp: same-cycle check failed");

// condition implies consequence in the next cycle
`define CCFP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ccfp: next-cycle check failed");

`endif

@@ design/ccfp_pkg.sv @@
// types, constants and the crc byte update for the command frame parser
`timescale 1ns / 1ps
`default_nettype none

package ccfp_pkg;

  localparam int unsigned ElapsedW = 17;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam int unsigned CRC_TOP_BIT = 15;
  localparam int unsigned MIN_FRAME = 17;
  localparam int unsigned CRC_SPAN = 15;
  localparam logic [7:0] HDR_FIRST = 8'h52;
  localparam logic [7:0] HDR_SECOND = 8'h4D;
  localparam logic [7:0] CMD_XYZ = 8'h01;
  localparam logic [7:0] CMD_ANGLES = 8'h03;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
  localparam logic [ElapsedW-1:0] ELAPSED_MAX = 17'h1FFFF;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    EV_XYZ      = 2'd0,
    EV_ANGLES   = 2'd1,
    EV_CRC_FAIL = 2'd2,
    EV_STOP     = 2'd3
  } event_kind_e;

  typedef logic [2:0][3:0][7:0] payload_t;

  typedef struct packed {
    logic       end_frame;
    logic       frame_ok;
    logic       crc_match;
    logic [7:0] command;
  } frame_info_t;

  // crc-16/ccitt-false, msb first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CRC_TOP_BIT]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/ccfp_frame.sv @@
// packet byte tracker: byte count, crc, header, command, payload and received crc
`timescale 1ns / 1ps
`default_nettype none

module ccfp_frame import ccfp_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 255
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        byte_en_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_i,
  output frame_info_t      info_o,
  output payload_t         words_o
);

  localparam int unsigned CntW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PACKET_BYTES);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     crc_q, crc_d;
  logic            hdr_q, hdr_d;
  logic [7:0]      cmd_q, cmd_d;
  payload_t        words_q, words_d;
  logic [15:0]     rxcrc_q, rxcrc_d;
  logic [3:0]      rel;
  logic            take;

  assign take = byte_en_i && (cnt_q < MaxCnt);
  assign rel  = 4'(cnt_q - CntW'(3));

  always_comb begin
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    hdr_d   = hdr_q;
    cmd_d   = cmd_q;
    words_d = words_q;
    rxcrc_d = rxcrc_q;
    if (take) begin
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q < CntW'(CRC_SPAN)) begin
        crc_d = crc16_byte(crc_q, data_byte_i);
      end
      priority if (cnt_q == CntW'(0)) begin
        hdr_d = (data_byte_i == HDR_FIRST);
      end else if (cnt_q == CntW'(1)) begin
        hdr_d = hdr_q && (data_byte_i == HDR_SECOND);
      end else if (cnt_q == CntW'(2)) begin
        cmd_d = data_byte_i;
      end else if (cnt_q < CntW'(15)) begin
        // bytes 3..14 fill the three words little endian
        words_d[rel[3:2]][rel[1:0]] = data_byte_i;
      end else if (cnt_q == CntW'(15)) begin
        rxcrc_d[7:0] = data_byte_i;
      end else if (cnt_q == CntW'(16)) begin
        rxcrc_d[15:8] = data_byte_i;
      end else begin
        // bytes past the received crc only advance the count
        hdr_d = hdr_q;
      end
    end
  end

  assign info_o = '{
    end_frame: byte_en_i && last_i,
    frame_ok:  (cnt_d >= CntW'(MIN_FRAME)) && hdr_d,
    crc_match: (rxcrc_d == crc_d),
    command:   cmd_d
  };
  assign words_o = words_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      crc_q   <= CRC_INIT;
      hdr_q   <= 1'b0;
      cmd_q   <= '0;
      words_q <= '0;
      rxcrc_q <= '0;
    end else if (byte_en_i && last_i) begin
      // packet end returns all packet state to its reset values
      cnt_q   <= '0;
      crc_q   <= CRC_INIT;
      hdr_q   <= 1'b0;
      cmd_q   <= '0;
      words_q <= '0;
      rxcrc_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      hdr_q   <= hdr_d;
      cmd_q   <= cmd_d;
      words_q <= words_d;
      rxcrc_q <= rxcrc_d;
    end
  end

`include "crc_checked_command_frame_parser_core_assert.svh"

  `CCFP_ASSERT_NEXT(a_end_clears_count, byte_en_i && last_i, cnt_q == '0 && crc_q == CRC_INIT)
  `CCFP_ASSERT_NEXT(a_count_saturates, byte_en_i && !last_i && cnt_q == MaxCnt, cnt_q == MaxCnt)
  `CCFP_ASSERT_SAME(a_header_needs_bytes, hdr_q, cnt_q != '0)

endmodule

`default_nettype wire

@@ design/crc_checked_command_frame_parser_core.sv @@
// crc-checked command frame parser with a motion watchdog, top level
// output: a result is registered and appears in the cycle after its item is accepted
// throughput: one item per cycle while s_axis_tready is high; the crc byte update is an unrolled combinational step
// s_axis_tready stays high while the output register is empty or being drained
// reset: asynchronous, active low; clears packet state, watchdog count and output valid,
// and loads the watchdog timeout with 2000
`timescale 1ns / 1ps
`default_nettype none

module crc_checked_command_frame_parser_core import ccfp_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 255
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [7:0] data_byte, [8] motor_moving, [15:9] zero
  input  wire logic        s_axis_tlast,
  input  wire logic        s_axis_tuser,  // [0] op
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [95:0] m_axis_tdata,  // [31:0] word_first, [63:32] word_second,
                                          // [95:64] word_third
  output      logic [1:0]  m_axis_tuser   // [1:0] event_kind
);

  logic                timed_out;
  logic [15:0]         timeout_ms_q;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic                in_fire, is_tick, byte_en, moving;
  frame_info_t         frame;
  payload_t            words;
  logic                res_valid;
  event_kind_e         res_kind;
  payload_t            res_words;
  logic                out_valid_q;
  event_kind_e         out_kind_q;
  payload_t            out_words_q;
  logic                frame_good;
  logic                out_plain;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_tick       = (s_axis_tuser == OP_TICK);
  assign byte_en       = in_fire && !is_tick;
  assign moving        = s_axis_tdata[8];

  ccfp_frame #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_en_i  (byte_en),
    .data_byte_i(s_axis_tdata[7:0]),
    .last_i     (s_axis_tlast),
    .info_o     (frame),
    .words_o    (words)
  );

  assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + ElapsedW'(1);
  assign timed_out   = (elapsed_inc > {1'b0, timeout_ms_q});

  always_comb begin
    elapsed_d = elapsed_q;
    res_valid = 1'b0;
    res_kind  = EV_STOP;
    res_words = '0;
    if (in_fire) begin
      if (is_tick) begin
        elapsed_d = elapsed_inc;
        if (timed_out && moving) begin
          res_valid = 1'b1;
          res_kind  = EV_STOP;
        end
      end else if (frame.end_frame && frame.frame_ok) begin
        if (frame.crc_match) begin
          elapsed_d = '0;
          if (frame.command == CMD_XYZ) begin
            res_valid = 1'b1;
            res_kind  = EV_XYZ;
            res_words = words;
          end else if (frame.command == CMD_ANGLES) begin
            res_valid = 1'b1;
            res_kind  = EV_ANGLES;
            res_words = words;
          end
        end else begin
          res_valid = 1'b1;
          res_kind  = EV_CRC_FAIL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ms_q <= TIMEOUT_RESET;
      elapsed_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_ms_q <= cfg_wdata_i;
      end
      elapsed_q <= elapsed_d;
      if (in_fire) begin
        out_valid_q <= res_valid;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_kind_q  <= EV_XYZ;
      out_words_q <= '0;
    end else if (in_fire && res_valid) begin
      out_kind_q  <= res_kind;
      out_words_q <= res_words;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_words_q;
  assign m_axis_tuser  = out_kind_q;

  assign frame_good = frame.end_frame && frame.frame_ok && frame.crc_match;
  assign out_plain  = m_axis_tvalid && (m_axis_tuser == EV_STOP || m_axis_tuser == EV_CRC_FAIL);

`include "crc_checked_command_frame_parser_core_assert.svh"

  `CCFP_ASSERT_SAME(a_no_words_off_move, out_plain, m_axis_tdata == '0)
  `CCFP_ASSERT_NEXT(a_good_frame_clears_count, byte_en && frame_good, elapsed_q == '0)
  `CCFP_ASSERT_NEXT(a_idle_tick_no_result, in_fire && is_tick && !moving, !m_axis_tvalid)

endmodule

`default_nettype wire
